// ===== src/rsti_pkg.sv =====
// Shared types and constants of the radix string to integer converter.
`default_nettype none

package rsti_pkg;

	localparam int SYMBOL_SLOTS = 16;
	localparam int SYM_W        = 8;
	localparam int DIGIT_W      = 4;
	localparam int COUNT_W      = 5;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 64;
	localparam int OUT_W        = 32;
	localparam int MIN_SYMBOLS  = 2;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = 2;

	localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;
	localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
	localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

	localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_LENGTH  = 2'd2;

	// one classified character
	typedef struct packed {
		logic               final_char;
		logic               skip;
		logic               minus;
		logic               is_digit;
		logic [DIGIT_W-1:0] digit;
	} item_t;

	// alphabet status derived from the configuration
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               alphabet_ok;
	} cfg_status_t;

endpackage

`default_nettype wire

// ===== src/radix_string_to_integer.sv =====
// Top level of the radix string to integer converter.
`default_nettype none

// Parses a string, one character per beat, into a signed integer. Leading spaces and
// '+'/'-' signs are skipped (an odd number of '-' makes the result negative); then
// digits are read, each digit's value being its position in the configured alphabet
// (symbols_low/symbols_high, base_length symbols in use). One result beat follows
// each character beat flagged final_char; it is 0 when the alphabet is invalid or
// no digit follows the prefix. While char_stall is low one character is taken every
// clock cycle: the front end classifies a character against all symbols in parallel
// and the back end does one multiply-add per cycle unless the result side stalls; a
// four-entry queue between front and back absorbs stalls on the result side. Write
// the configuration only while no string is in flight.
module radix_string_to_integer #(
	parameter int MAX_SYMBOLS = 16,
	parameter int VALUE_BITS  = 32
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_write,
	input  wire  [rsti_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  wire  [rsti_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire  [rsti_pkg::SYM_W-1:0]             character,
	input  wire                                    final_char,
	input  wire                                    char_valid,
	output logic                                   char_stall,
	output logic signed [rsti_pkg::OUT_W-1:0]      value,
	output logic                                   result_valid,
	input  wire                                    result_stall
);

	rsti_pkg::cfg_status_t status;
	rsti_pkg::item_t       push_item;
	rsti_pkg::item_t       head;
	logic                  push;
	logic                  pop;
	logic                  queue_full;
	logic                  not_empty;

	rsti_front #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.character  (character),
		.final_char (final_char),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item),
		.status     (status)
	);

	rsti_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.pop_item  (head),
		.not_empty (not_empty)
	);

	rsti_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.status       (status),
		.not_empty    (not_empty),
		.head         (head),
		.pop          (pop),
		.value        (value),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

`default_nettype wire

// ===== src/rsti_front.sv =====
// Front end: configuration registers, alphabet check, character classification.
`default_nettype none

module rsti_front #(
	parameter int MAX_SYMBOLS = 16
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  wire                                       cfg_write,
	input  wire  [rsti_pkg::CFG_INDEX_W-1:0]          cfg_index,
	input  wire  [rsti_pkg::CFG_DATA_W-1:0]           cfg_data,
	input  wire  [rsti_pkg::SYM_W-1:0]                character,
	input  wire                                       final_char,
	input  wire                                       char_valid,
	output logic                                      char_stall,
	input  wire                                       queue_full,
	output logic                                      push,
	output rsti_pkg::item_t                           push_item,
	output rsti_pkg::cfg_status_t                     status
);

	localparam int NSYM = (MAX_SYMBOLS < rsti_pkg::SYMBOL_SLOTS) ?
		MAX_SYMBOLS : rsti_pkg::SYMBOL_SLOTS;

	logic [rsti_pkg::CFG_DATA_W-1:0] symbols_low_q;
	logic [rsti_pkg::CFG_DATA_W-1:0] symbols_high_q;
	logic [rsti_pkg::COUNT_W-1:0]    base_length_q;
	logic                            alphabet_ok_q;

	logic [rsti_pkg::SYMBOL_SLOTS-1:0][rsti_pkg::SYM_W-1:0] sym;
	logic [rsti_pkg::COUNT_W-1:0] count;
	logic                         alphabet_ok;
	logic                         hit;
	logic [rsti_pkg::DIGIT_W-1:0] hit_idx;
	rsti_pkg::item_t              item;
	rsti_pkg::item_t              item_s1;
	logic                         valid_s1;
	logic                         accept;

	assign sym = {symbols_high_q, symbols_low_q};

	assign count = (base_length_q > rsti_pkg::COUNT_W'(NSYM)) ?
		rsti_pkg::COUNT_W'(NSYM) : base_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbols_low_q  <= '0;
			symbols_high_q <= '0;
			base_length_q  <= '0;
			alphabet_ok_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					rsti_pkg::REG_SYMBOLS_LOW:  symbols_low_q  <= cfg_data;
					rsti_pkg::REG_SYMBOLS_HIGH: symbols_high_q <= cfg_data;
					rsti_pkg::REG_BASE_LENGTH:
						base_length_q <= cfg_data[rsti_pkg::COUNT_W-1:0];
					default: ;
				endcase
			end
			alphabet_ok_q <= alphabet_ok;
		end
	end

	// symbol count check, NUL/'+'/'-' ban and pairwise check of the symbols in use
	always_comb begin
		alphabet_ok = (count >= rsti_pkg::COUNT_W'(rsti_pkg::MIN_SYMBOLS));
		for (int i = 0; i < NSYM; i++) begin
			if (rsti_pkg::COUNT_W'(i) < count) begin
				if (sym[i] == rsti_pkg::CH_NUL || sym[i] == rsti_pkg::CH_PLUS ||
				    sym[i] == rsti_pkg::CH_MINUS)
					alphabet_ok = 1'b0;
				for (int j = i + 1; j < NSYM; j++) begin
					if (rsti_pkg::COUNT_W'(j) < count && sym[j] == sym[i])
						alphabet_ok = 1'b0;
				end
			end
		end
	end

	// first matching symbol wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = NSYM - 1; i >= 0; i--) begin
			if (rsti_pkg::COUNT_W'(i) < count && sym[i] == character) begin
				hit     = 1'b1;
				hit_idx = rsti_pkg::DIGIT_W'(i);
			end
		end
		if (character == rsti_pkg::CH_NUL)
			hit = 1'b0;
	end

	always_comb begin
		item.final_char = final_char;
		item.skip       = (character == rsti_pkg::CH_SPACE) ||
		                  (character == rsti_pkg::CH_PLUS);
		item.minus      = (character == rsti_pkg::CH_MINUS);
		item.is_digit   = hit;
		item.digit      = hit_idx;
	end

	assign char_stall = valid_s1 && queue_full;
	assign accept     = char_valid && !char_stall;
	assign push       = valid_s1 && !queue_full;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item;
	end

	assign status.count       = count;
	assign status.alphabet_ok = alphabet_ok_q;

endmodule

`default_nettype wire

// ===== src/rsti_queue.sv =====
// Short queue of classified characters between front and back end.
`default_nettype none

module rsti_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  rsti_pkg::item_t  push_item,
	output logic             full,
	input  wire              pop,
	output rsti_pkg::item_t  pop_item,
	output logic             not_empty
);

	rsti_pkg::item_t                mem [rsti_pkg::QUEUE_DEPTH];
	logic [rsti_pkg::QPTR_W-1:0]    wr_q;
	logic [rsti_pkg::QPTR_W-1:0]    rd_q;
	logic [rsti_pkg::QPTR_W:0]      fill_q;

	assign full      = (fill_q == (rsti_pkg::QPTR_W + 1)'(rsti_pkg::QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign pop_item  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/rsti_back.sv =====
// Back end: sign and digit accumulation, result register.
`default_nettype none

module rsti_back #(
	parameter int VALUE_BITS = 32
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  rsti_pkg::cfg_status_t                 status,
	input  wire                                   not_empty,
	input  rsti_pkg::item_t                       head,
	output logic                                  pop,
	output logic signed [rsti_pkg::OUT_W-1:0]     value,
	output logic                                  result_valid,
	input  wire                                   result_stall
);

	typedef enum logic [1:0] {
		PH_PREFIX,
		PH_DIGITS,
		PH_STOPPED,
		PH_REJECTED
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic                    negative_q, negative_d;
	logic [VALUE_BITS-1:0]   acc_q, acc_d;
	logic [VALUE_BITS-1:0]   prod;
	logic [VALUE_BITS-1:0]   result;
	logic                    out_free;
	logic                    result_valid_q;
	logic [rsti_pkg::OUT_W-1:0] value_q;

	assign out_free = !result_valid_q || !result_stall;
	assign pop      = not_empty && (!head.final_char || out_free);

	assign prod = acc_q * VALUE_BITS'(status.count);

	always_comb begin
		phase_d    = phase_q;
		negative_d = negative_q;
		acc_d      = acc_q;
		case (phase_q)
			PH_PREFIX: begin
				if (head.skip) begin
					phase_d = PH_PREFIX;
				end else if (head.minus) begin
					negative_d = !negative_q;
				end else if (head.is_digit) begin
					acc_d   = VALUE_BITS'(head.digit);
					phase_d = PH_DIGITS;
				end else begin
					phase_d = PH_REJECTED;
				end
			end
			PH_DIGITS: begin
				if (head.is_digit)
					acc_d = prod + VALUE_BITS'(head.digit);
				else
					phase_d = PH_STOPPED;
			end
			default: ;
		endcase
	end

	always_comb begin
		result = '0;
		if ((phase_d == PH_DIGITS || phase_d == PH_STOPPED) && status.alphabet_ok)
			result = negative_d ? -acc_d : acc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_PREFIX;
			negative_q     <= 1'b0;
			acc_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop && head.final_char) begin
				// string done: back to the prefix phase
				phase_q        <= PH_PREFIX;
				negative_q     <= 1'b0;
				acc_q          <= '0;
				result_valid_q <= 1'b1;
			end else begin
				if (pop) begin
					phase_q    <= phase_d;
					negative_q <= negative_d;
					acc_q      <= acc_d;
				end
				if (!result_stall)
					result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.final_char)
			value_q <= rsti_pkg::OUT_W'(result);
	end

	assign value        = value_q;
	assign result_valid = result_valid_q;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the radix string to integer converter.
`default_nettype none

module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_CHARS  = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int SHOWN_FAILS   = 40;

	localparam logic [63:0] DEC_LO  = 64'h3736_3534_3332_3130; // "01234567"
	localparam logic [63:0] HEX_HI  = 64'h4645_4443_4241_3938; // "89ABCDEF"
	localparam logic [63:0] PLUS_LO = 64'h3736_3534_3332_2B30; // '+' as symbol 1
	localparam logic [63:0] DUP_LO  = 64'h3736_3534_3332_3030; // symbols 0 and 1 equal
	localparam logic [63:0] NUL_LO  = 64'h3736_3534_3332_0030; // zero byte as symbol 1

	typedef enum logic [1:0] {SCAN_PREFIX, SCAN_DIGITS, SCAN_STOPPED, SCAN_REJECTED} scan_t;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	typedef struct {
		bit                         is_cfg;
		logic [rsti_pkg::SYM_W-1:0] ch;
		logic                       last;
		bit                         known;
		logic signed [31:0]         want;
		logic [63:0]                lo;
		logic [63:0]                hi;
		logic [4:0]                 base;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [rsti_pkg::CFG_INDEX_W-1:0] cfg_index = rsti_pkg::REG_SYMBOLS_LOW;
	logic [rsti_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic [rsti_pkg::SYM_W-1:0] character = '0;
	logic final_char = 1'b0;
	logic char_valid = 1'b0;
	logic char_stall;
	logic signed [rsti_pkg::OUT_W-1:0] value;
	logic result_valid;
	logic result_stall = 1'b0;

	// predictor copy of configuration and parse state
	logic [63:0] sym_lo;
	logic [63:0] sym_hi;
	logic [4:0] base_len;
	scan_t scan_state;
	logic neg_flag;
	logic [31:0] acc;

	logic signed [31:0] expected_values[$];
	plan_row_t plan[$];
	int fail_count = 0;
	int cycles = 0;
	int chars_sent = 0;
	int burst_left = 0;
	bit valid_up = 1'b0;
	int stall_ticks = 0;
	stall_mode_t stall_mode = STALL_NONE;

	radix_string_to_integer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.character(character),
		.final_char(final_char),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.value(value),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d values outstanding", $time, expected_values.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int unsigned alpha_count();
		return (base_len > rsti_pkg::SYMBOL_SLOTS) ? rsti_pkg::SYMBOL_SLOTS : base_len;
	endfunction

	function automatic logic [rsti_pkg::SYM_W-1:0] alpha_sym(input int unsigned i);
		return (i < 8) ? sym_lo[i*8 +: 8] : sym_hi[(i-8)*8 +: 8];
	endfunction

	// position of the first matching symbol, -1 if not a digit
	function automatic int digit_value(input logic [rsti_pkg::SYM_W-1:0] c);
		if (c == rsti_pkg::CH_NUL)
			return -1;
		for (int i = 0; i < alpha_count(); i++)
			if (alpha_sym(i) == c)
				return i;
		return -1;
	endfunction

	function automatic bit alphabet_valid();
		logic [rsti_pkg::SYM_W-1:0] s;
		if (alpha_count() < rsti_pkg::MIN_SYMBOLS)
			return 1'b0;
		for (int i = 0; i < alpha_count(); i++) begin
			s = alpha_sym(i);
			if (s == rsti_pkg::CH_NUL || s == rsti_pkg::CH_PLUS || s == rsti_pkg::CH_MINUS)
				return 1'b0;
			for (int j = i + 1; j < alpha_count(); j++)
				if (alpha_sym(j) == s)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// advances the parse by one character; returns 1 with the value on a final beat
	function automatic bit parse_char(input logic [rsti_pkg::SYM_W-1:0] c, input logic last,
			output logic signed [31:0] res);
		int d;
		d = digit_value(c);
		res = '0;
		case (scan_state)
			SCAN_PREFIX: begin
				if (c == rsti_pkg::CH_MINUS)
					neg_flag = ~neg_flag;
				else if (c == rsti_pkg::CH_SPACE || c == rsti_pkg::CH_PLUS) begin
					// skipped
				end else if (d >= 0) begin
					acc = 32'(d);
					scan_state = SCAN_DIGITS;
				end else
					scan_state = SCAN_REJECTED;
			end
			SCAN_DIGITS: begin
				if (d >= 0)
					acc = acc * 32'(alpha_count()) + 32'(d);
				else
					scan_state = SCAN_STOPPED;
			end
			default: begin
			end
		endcase
		if (!last)
			return 1'b0;
		if ((scan_state == SCAN_DIGITS || scan_state == SCAN_STOPPED) && alphabet_valid())
			res = neg_flag ? -acc : acc;
		scan_state = SCAN_PREFIX;
		neg_flag = 1'b0;
		acc = '0;
		return 1'b1;
	endfunction

	function automatic plan_row_t row_char(input logic [rsti_pkg::SYM_W-1:0] c);
		plan_row_t r;
		r = '{default: 0};
		r.ch = c;
		return r;
	endfunction

	function automatic plan_row_t row_end(input logic [rsti_pkg::SYM_W-1:0] c,
			input logic signed [31:0] want);
		plan_row_t r;
		r = row_char(c);
		r.last = 1'b1;
		r.known = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic plan_row_t row_alphabet(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] base);
		plan_row_t r;
		r = '{default: 0};
		r.is_cfg = 1'b1;
		r.lo = lo;
		r.hi = hi;
		r.base = base;
		return r;
	endfunction

	task automatic lower_valid();
		if (valid_up)
			char_valid <= 1'b0;
		valid_up = 1'b0;
	endtask

	task automatic feed_char(input logic [rsti_pkg::SYM_W-1:0] c, input logic last,
			input bit known, input logic signed [31:0] want);
		int unsigned gap;
		logic signed [31:0] got;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				lower_valid();
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		if (parse_char(c, last, got))
			expected_values.push_back(known ? want : got);
		character <= c;
		final_char <= last;
		char_valid <= 1'b1;
		valid_up = 1'b1;
		chars_sent++;
		do @(posedge clk); while (char_stall);
	endtask

	// sender idle, every value back, then the pipeline allowed to empty
	task automatic drain();
		lower_valid();
		while (expected_values.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_alphabet(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] base);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		cfg_index <= rsti_pkg::REG_SYMBOLS_LOW;
		cfg_data <= lo;
		cfg_write <= 1'b1;
		@(posedge clk);
		cfg_index <= rsti_pkg::REG_SYMBOLS_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		// only the low bits hold the length
		cfg_index <= rsti_pkg::REG_BASE_LENGTH;
		cfg_data <= {junk[63:5], base};
		@(posedge clk);
		cfg_write <= 1'b0;
		sym_lo = lo;
		sym_hi = hi;
		base_len = base;
	endtask

	task automatic pick_alphabet(input int force_base, output logic [63:0] lo,
			output logic [63:0] hi, output logic [4:0] base);
		logic [rsti_pkg::SYM_W-1:0] syms[rsti_pkg::SYMBOL_SLOTS];
		logic [rsti_pkg::SYM_W-1:0] b;
		bit clash;
		int unsigned roll, kind, n, a;
		for (int k = 0; k < rsti_pkg::SYMBOL_SLOTS; k++) begin
			do begin
				b = 8'($urandom_range(1, 255));
				clash = (b == rsti_pkg::CH_PLUS || b == rsti_pkg::CH_MINUS);
				for (int j = 0; j < k; j++)
					if (syms[j] == b)
						clash = 1'b1;
			end while (clash);
			syms[k] = b;
		end
		roll = $urandom_range(0, 19);
		if (force_base >= 0)
			base = 5'(force_base);
		else if (roll < 2)
			base = 5'd2;
		else if (roll < 4)
			base = 5'd16;
		else if (roll < 5)
			base = 5'($urandom_range(17, 31));
		else if (roll < 6)
			base = 5'($urandom_range(0, 1));
		else
			base = 5'($urandom_range(3, 15));
		n = (base > rsti_pkg::SYMBOL_SLOTS) ? rsti_pkg::SYMBOL_SLOTS : base;
		kind = (force_base >= 0) ? 0 : $urandom_range(0, 11);
		if (n >= rsti_pkg::MIN_SYMBOLS) begin
			case (kind)
				5: syms[$urandom_range(0, n-1)] = rsti_pkg::CH_SPACE;
				6: syms[$urandom_range(0, n-1)] =
					$urandom_range(0, 1) ? rsti_pkg::CH_PLUS : rsti_pkg::CH_MINUS;
				7: begin
					a = $urandom_range(1, n-1);
					syms[a] = syms[$urandom_range(0, a-1)];
				end
				8: syms[$urandom_range(0, n-1)] = rsti_pkg::CH_NUL;
				default: begin
				end
			endcase
		end
		for (int k = 0; k < rsti_pkg::SYMBOL_SLOTS; k++)
			if (k < 8)
				lo[k*8 +: 8] = syms[k];
			else
				hi[(k-8)*8 +: 8] = syms[k];
		if (kind == 9) begin
			lo = {$urandom, $urandom};
			hi = {$urandom, $urandom};
		end
	endtask

	// mostly sign prefix + digits + optional tail; some pure noise and broken digit runs
	task automatic random_string();
		logic [rsti_pkg::SYM_W-1:0] str[$];
		int unsigned n, len, roll;
		n = alpha_count();
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			len = $urandom_range(1, 8);
			repeat (len) str.push_back(8'($urandom_range(0, 255)));
		end else begin
			len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4);
			repeat (len) begin
				case ($urandom_range(0, 2))
					0: str.push_back(rsti_pkg::CH_SPACE);
					1: str.push_back(rsti_pkg::CH_PLUS);
					default: str.push_back(rsti_pkg::CH_MINUS);
				endcase
			end
			len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
			repeat (len) begin
				if (n == 0 || $urandom_range(0, 49) == 0)
					str.push_back(alpha_sym($urandom_range(0, rsti_pkg::SYMBOL_SLOTS-1)));
				else
					str.push_back(alpha_sym($urandom_range(0, n-1)));
				if (roll == 1 && $urandom_range(0, 5) == 0)
					str.push_back($urandom_range(0, 1) ? rsti_pkg::CH_NUL : 8'hFF);
			end
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 3)) str.push_back(8'($urandom_range(0, 255)));
			if (str.size() == 0)
				str.push_back(8'($urandom_range(0, 255)));
		end
		foreach (str[i])
			feed_char(str[i], i == str.size() - 1, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		logic signed [31:0] want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_values.size() == 0) begin
				fail_count++;
				if (fail_count <= SHOWN_FAILS)
					$display("%0t: value beat with none expected, expected none, got %0d",
						$time, value);
			end else begin
				want = expected_values.pop_front();
				if (value !== want) begin
					fail_count++;
					if (fail_count <= SHOWN_FAILS)
						$display("%0t: value mismatch, expected %0d, got %0d",
							$time, want, value);
				end
			end
		end
		stall_ticks++;
		if (stall_ticks % 300 == 0)
			stall_mode = stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_NONE: result_stall <= 1'b0;
			STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
			default: result_stall <= (stall_ticks % 7) < 3;
		endcase
	end

	initial begin
		logic [63:0] lo, hi;
		logic [4:0] base;
		int random_start, phase_no, phase_end;

		sym_lo = '0;
		sym_hi = '0;
		base_len = '0;
		scan_state = SCAN_PREFIX;
		neg_flag = 1'b0;
		acc = '0;

		plan.push_back(row_end("5", 0));              // all registers zero: no alphabet
		plan.push_back(row_alphabet(DEC_LO, HEX_HI, 5'd10));
		plan.push_back(row_char(" "));
		plan.push_back(row_char("-"));
		plan.push_back(row_end("7", -7));
		plan.push_back(row_char("-"));
		plan.push_back(row_char("-"));
		plan.push_back(row_char("1"));
		plan.push_back(row_end("2", 12));
		plan.push_back(row_end("x", 0));
		plan.push_back(row_char("3"));
		plan.push_back(row_char(rsti_pkg::CH_NUL));   // zero byte ends the digits
		plan.push_back(row_end("5", 3));
		plan.push_back(row_end(" ", 0));
		plan.push_back(row_end("-", 0));
		plan.push_back(row_end(8'hFF, 0));
		plan.push_back(row_char("+"));
		plan.push_back(row_end("9", 9));
		plan.push_back(row_alphabet(DEC_LO, HEX_HI, 5'd31)); // saturates to 16 symbols
		plan.push_back(row_char("-"));
		plan.push_back(row_char("F"));
		plan.push_back(row_end("F", -255));
		plan.push_back(row_alphabet(DEC_LO, HEX_HI, 5'd1));
		plan.push_back(row_end("0", 0));
		plan.push_back(row_alphabet(PLUS_LO, HEX_HI, 5'd2));
		plan.push_back(row_end("0", 0));
		plan.push_back(row_alphabet(DUP_LO, HEX_HI, 5'd2));
		plan.push_back(row_end("0", 0));
		plan.push_back(row_alphabet(NUL_LO, HEX_HI, 5'd3));
		plan.push_back(row_end("2", 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				load_alphabet(plan[i].lo, plan[i].hi, plan[i].base);
			end else
				feed_char(plan[i].ch, plan[i].last, plan[i].known, plan[i].want);
		end

		// first two alphabets are valid at the largest and smallest radix
		random_start = chars_sent;
		phase_no = 0;
		while (chars_sent - random_start < RANDOM_CHARS) begin
			drain();
			pick_alphabet(phase_no == 0 ? 16 : (phase_no == 1 ? 2 : -1), lo, hi, base);
			load_alphabet(lo, hi, base);
			phase_end = chars_sent + $urandom_range(100, 300);
			while (chars_sent < phase_end)
				random_string();
			phase_no++;
		end
		drain();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
src/rsti_pkg.sv
src/rsti_front.sv
src/rsti_queue.sv
src/rsti_back.sv
src/radix_string_to_integer.sv
tb/sv/testbench.sv
